// ===== rtl/core/cpr_pkg.sv =====
// Types and codes shared by the chunk pull responder.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int unsigned SeqW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_FRAME  = 3'd1,
    REQ_RX_ERR = 3'd2,
    REQ_IDLE   = 3'd3,
    REQ_CHFAIL = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_GET   = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_OTHER = 2'd3
  } frame_kind_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_READY = 3'd1,
    ACT_SERVE = 3'd2,
    ACT_WAIT  = 3'd3,
    ACT_DONE  = 3'd4,
    ACT_ABORT = 3'd5,
    ACT_CHERR = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    WHY_BADCOUNT  = 3'd0,
    WHY_EARLYDONE = 3'd1,
    WHY_NOGET     = 3'd2,
    WHY_NODONE    = 3'd3,
    WHY_QUIET     = 3'd4,
    WHY_HOSTABORT = 3'd5
  } why_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_SEQ   = 3'd0,
    CFG_CHUNK_COUNT    = 3'd1,
    CFG_STALE_LIMIT    = 3'd2,
    CFG_READY_ATTEMPTS = 3'd3,
    CFG_WAIT_LIMIT     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SeqW-1:0] expected_seq;
    logic [5:0]      chunk_count;
    logic [7:0]      stale_limit;
    logic [3:0]      ready_attempts;
    logic [3:0]      wait_limit;
  } cfg_t;

  typedef struct packed {
    logic            pull_active;
    logic [31:0]     served_map;
    logic [7:0]      stale_run;
    logic [3:0]      ready_sent_count;
    logic [3:0]      wait_sent_count;
    logic            any_get_seen;
    logic [15:0]     stale_counter;
    logic [15:0]     served_counter;
    logic [5:0]      expiry_counter;
  } state_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic            frame_well_formed;
    logic [1:0]      frame_kind;
    logic [SeqW-1:0] frame_seq;
    logic [SeqW-1:0] payload_seq;
    logic            chunk_named;
    logic [31:0]     chunk_index;
  } req_t;

  typedef struct packed {
    action_e         action;
    logic [4:0]      served_chunk;
    logic [5:0]      unique_served;
    why_e            abort_reason;
    logic [15:0]     stale_total;
    logic [15:0]     chunks_served_total;
    logic [5:0]      expiry_total;
    logic [31:0]     served_bits;
  } rsp_t;

endpackage

// ===== rtl/core/cpr_stream_if.sv =====
// Valid/ready stream channel carrying one word of type T.
// Depends on nothing; T is set where the channel is instantiated.
`timescale 1ns / 1ps

interface cpr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cpr_decide.sv =====
// Next-state and result decision for one event of the chunk pull responder.
// Purely combinational; uses cpr_pkg types and codes.
`timescale 1ns / 1ps

module cpr_decide #(
  parameter int unsigned MAX_CHUNKS = 32
) (
  input  cpr_pkg::cfg_t   cfg_i,
  input  cpr_pkg::state_t st_i,
  input  cpr_pkg::req_t   req_i,
  output cpr_pkg::state_t st_o,
  output cpr_pkg::rsp_t   rsp_o
);

  logic [31:0]      want_mask;
  logic             all_marked;
  logic             seq_ok;
  logic             chunk_ok;
  logic             bad_count;
  logic [7:0]       run_inc;
  logic             do_stale;
  logic             do_expiry;
  cpr_pkg::action_e act;
  cpr_pkg::why_e    why;
  logic [4:0]       served;
  cpr_pkg::state_t  nxt;

  always_comb begin
    want_mask  = (cfg_i.chunk_count >= 6'd32) ? '1
               : ((32'd1 << cfg_i.chunk_count) - 32'd1);
    all_marked = (st_i.served_map & want_mask) == want_mask;
    seq_ok     = req_i.frame_well_formed && (req_i.frame_seq == cfg_i.expected_seq)
               && (req_i.payload_seq == cfg_i.expected_seq);
    chunk_ok   = req_i.chunk_named && (req_i.chunk_index < 32'(cfg_i.chunk_count))
               && (req_i.chunk_index < 32'(MAX_CHUNKS));
    bad_count  = (cfg_i.chunk_count == 6'd0)
               || ({1'b0, cfg_i.chunk_count} > 7'(MAX_CHUNKS));
    run_inc    = (st_i.stale_run == 8'hFF) ? st_i.stale_run : st_i.stale_run + 8'd1;
  end

  always_comb begin
    nxt       = st_i;
    act       = cpr_pkg::ACT_NONE;
    why       = cpr_pkg::WHY_BADCOUNT;
    served    = '0;
    do_stale  = 1'b0;
    do_expiry = 1'b0;

    if (req_i.req_type == cpr_pkg::REQ_START) begin
      nxt = '0;
      if (bad_count) begin
        act = cpr_pkg::ACT_ABORT;
        why = cpr_pkg::WHY_BADCOUNT;
      end else begin
        nxt.pull_active      = 1'b1;
        nxt.ready_sent_count = 4'd1;
        act                  = cpr_pkg::ACT_READY;
      end
    end else if (st_i.pull_active) begin
      case (req_i.req_type)
        cpr_pkg::REQ_CHFAIL: begin
          nxt.pull_active = 1'b0;
          act             = cpr_pkg::ACT_CHERR;
        end
        cpr_pkg::REQ_IDLE:   do_expiry = 1'b1;
        cpr_pkg::REQ_RX_ERR: do_stale = 1'b1;
        cpr_pkg::REQ_FRAME: begin
          if (!seq_ok) begin
            do_stale = 1'b1;
          end else begin
            case (req_i.frame_kind)
              cpr_pkg::KIND_GET: begin
                // any sequence-valid GET restarts the stale run
                nxt.stale_run = '0;
                if (chunk_ok) begin
                  nxt.any_get_seen   = 1'b1;
                  nxt.served_counter = (st_i.served_counter == 16'hFFFF)
                                     ? st_i.served_counter : st_i.served_counter + 16'd1;
                  nxt.served_map     = st_i.served_map | (32'd1 << req_i.chunk_index[4:0]);
                  served             = req_i.chunk_index[4:0];
                  act                = cpr_pkg::ACT_SERVE;
                end else if (st_i.stale_counter != 16'hFFFF) begin
                  nxt.stale_counter = st_i.stale_counter + 16'd1;
                end
              end
              cpr_pkg::KIND_DONE: begin
                nxt.pull_active = 1'b0;
                if (all_marked) begin
                  act = cpr_pkg::ACT_DONE;
                end else begin
                  act = cpr_pkg::ACT_ABORT;
                  why = cpr_pkg::WHY_EARLYDONE;
                end
              end
              cpr_pkg::KIND_ABORT: begin
                nxt.pull_active = 1'b0;
                act             = cpr_pkg::ACT_ABORT;
                why             = cpr_pkg::WHY_HOSTABORT;
              end
              default: do_stale = 1'b1;
            endcase
          end
        end
        default: ;
      endcase
    end

    if (do_stale) begin
      nxt.stale_counter = (st_i.stale_counter == 16'hFFFF)
                        ? st_i.stale_counter : st_i.stale_counter + 16'd1;
      nxt.stale_run     = run_inc;
      if (run_inc >= cfg_i.stale_limit) begin
        do_expiry = 1'b1;
      end
    end

    if (do_expiry) begin
      nxt.stale_run      = '0;
      nxt.expiry_counter = (st_i.expiry_counter == 6'd63)
                         ? st_i.expiry_counter : st_i.expiry_counter + 6'd1;
      if (!st_i.any_get_seen) begin
        if (st_i.ready_sent_count >= cfg_i.ready_attempts) begin
          nxt.pull_active = 1'b0;
          act             = cpr_pkg::ACT_ABORT;
          why             = cpr_pkg::WHY_NOGET;
        end else begin
          nxt.ready_sent_count = (st_i.ready_sent_count == 4'hF)
                               ? st_i.ready_sent_count : st_i.ready_sent_count + 4'd1;
          act                  = cpr_pkg::ACT_READY;
        end
      end else if (all_marked) begin
        if (st_i.wait_sent_count >= cfg_i.wait_limit) begin
          nxt.pull_active = 1'b0;
          act             = cpr_pkg::ACT_ABORT;
          why             = cpr_pkg::WHY_NODONE;
        end else begin
          nxt.wait_sent_count = (st_i.wait_sent_count == 4'hF)
                              ? st_i.wait_sent_count : st_i.wait_sent_count + 4'd1;
          act                 = cpr_pkg::ACT_WAIT;
        end
      end else begin
        nxt.pull_active = 1'b0;
        act             = cpr_pkg::ACT_ABORT;
        why             = cpr_pkg::WHY_QUIET;
      end
    end
  end

  always_comb begin
    st_o                      = nxt;
    rsp_o.action              = act;
    rsp_o.served_chunk        = served;
    rsp_o.unique_served       = 6'($countones(nxt.served_map));
    rsp_o.abort_reason        = (act == cpr_pkg::ACT_ABORT) ? why : cpr_pkg::WHY_BADCOUNT;
    rsp_o.stale_total         = nxt.stale_counter;
    rsp_o.chunks_served_total = nxt.served_counter;
    rsp_o.expiry_total        = nxt.expiry_counter;
    rsp_o.served_bits         = nxt.served_map;
  end

endmodule

// ===== rtl/core/cpr_skid.sv =====
// Two-entry result buffer: output register plus skid register.
// Uses cpr_pkg::rsp_t and drives a cpr_stream_if source.
`timescale 1ns / 1ps

module cpr_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  cpr_pkg::rsp_t        in_data_i,
  output logic                 in_ready_o,
  cpr_stream_if.source         out_o
);

  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  cpr_pkg::rsp_t out_data_q, out_data_d;
  cpr_pkg::rsp_t skid_data_q, skid_data_d;
  logic          pop;

  assign in_ready_o = !skid_valid_q;
  assign pop        = out_o.ready || !out_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        // drain the skid word first; input is held off while it is full
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        if (in_valid_i) begin
          out_data_d = in_data_i;
        end
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== rtl/core/chunk_pull_responder.sv =====
// Chunk pull responder: one result word for every accepted event word.
// Results are registered. Throughput: one event per cycle while the skid
// register is empty; the decision logic is a single pass from the pull state
// registers to the result register, and a skid register lets one more event
// in while a result waits. Ready depends only on that skid.
// Reset: pull idle, counters and mask zero, registers at their reset values.
`timescale 1ns / 1ps

module chunk_pull_responder #(
  parameter int unsigned MAX_CHUNKS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cpr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  cpr_stream_if.sink                    req_i,
  cpr_stream_if.source                  rsp_o
);

  cpr_pkg::cfg_t   cfg_q;
  cpr_pkg::state_t st_q, st_d;
  cpr_pkg::rsp_t   rsp_d;
  logic            in_ready;
  logic            accept;

  assign req_i.ready = in_ready;
  assign accept      = req_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_seq   <= '0;
      cfg_q.chunk_count    <= 6'd1;
      cfg_q.stale_limit    <= 8'd8;
      cfg_q.ready_attempts <= 4'd3;
      cfg_q.wait_limit     <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpr_pkg::CFG_EXPECTED_SEQ:   cfg_q.expected_seq   <= cfg_wdata_i;
        cpr_pkg::CFG_CHUNK_COUNT:    cfg_q.chunk_count    <= cfg_wdata_i[5:0];
        cpr_pkg::CFG_STALE_LIMIT:    cfg_q.stale_limit    <= cfg_wdata_i[7:0];
        cpr_pkg::CFG_READY_ATTEMPTS: cfg_q.ready_attempts <= cfg_wdata_i[3:0];
        cpr_pkg::CFG_WAIT_LIMIT:     cfg_q.wait_limit     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  cpr_decide #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_decide (
    .cfg_i (cfg_q),
    .st_i  (st_q),
    .req_i (req_i.data),
    .st_o  (st_d),
    .rsp_o (rsp_d)
  );

  // advance the pull state only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  cpr_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_data_i  (rsp_d),
    .in_ready_o (in_ready),
    .out_o      (rsp_o)
  );

endmodule

// ===== rtl/core/cpr_checker.sv =====
// Port-level checks on the result channel of the chunk pull responder.
// Uses cpr_pkg codes; attached to chunk_pull_responder by the bind below.
`timescale 1ns / 1ps

module cpr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cpr_pkg::rsp_t rsp_data
);

  // hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.action == cpr_pkg::ACT_SERVE
    |-> rsp_data.served_bits[rsp_data.served_chunk] && rsp_data.chunks_served_total != 16'd0)
    else $error("served chunk missing from mask or count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.abort_reason != cpr_pkg::WHY_BADCOUNT
    |-> rsp_data.action == cpr_pkg::ACT_ABORT)
    else $error("abort reason without abort");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_data.unique_served == 6'($countones(rsp_data.served_bits)))
    else $error("unique count disagrees with mask");

endmodule

bind chunk_pull_responder cpr_checker u_cpr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_data  (rsp_o.data)
);
